// ----- design/hpse_pkg.sv -----
`timescale 1ns / 1ps

package hpse_pkg;

    // Record layout
    localparam int HEADER_BYTES     = 22;
    localparam int LSIZE_BYTE_POS   = 21;
    localparam int MIN_RECORD_BYTES = 23;
    localparam int START_CODE_BYTES = 4;
    localparam int POS_W            = 7;
    localparam int CNT_W            = 3;
    localparam int TOTAL_W          = 17;

    localparam logic [5:0] TYPE_MASK  = 6'h3F;
    localparam logic [1:0] LSIZE_MASK = 2'h3;

    // Configuration register indexes
    localparam logic [1:0] REG_KEEP_FIRST  = 2'd0;
    localparam logic [1:0] REG_KEEP_SECOND = 2'd1;
    localparam logic [1:0] REG_KEEP_THIRD  = 2'd2;

    localparam logic [5:0] KEEP_FIRST_RST  = 6'd32;
    localparam logic [5:0] KEEP_SECOND_RST = 6'd33;
    localparam logic [5:0] KEEP_THIRD_RST  = 6'd34;

    // Result kinds
    localparam logic [1:0] KIND_NALU   = 2'd0;
    localparam logic [1:0] KIND_LSIZE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Record status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_COUNT     = 3'd1,
        PH_TYPE      = 3'd2,
        PH_NCOUNT_HI = 3'd3,
        PH_NCOUNT_LO = 3'd4,
        PH_LEN_HI    = 3'd5,
        PH_LEN_LO    = 3'd6,
        PH_PAYLOAD   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [5:0] keep_first;
        logic [5:0] keep_second;
        logic [5:0] keep_third;
    } keep_cfg_t;

    // Results caused by one input byte, emitted in field order
    typedef struct packed {
        logic               has_lsize;
        logic [2:0]         lsize;
        logic               has_sc;
        logic               sc_end;
        logic               has_byte;
        logic [7:0]         data;
        logic               byte_end;
        logic [TOTAL_W-1:0] total;
        logic               has_status;
        logic [1:0]         status;
        logic [CNT_W-1:0]   count;
    } bundle_t;

endpackage

// ----- design/hvcc_parameter_set_extractor.sv -----
`timescale 1ns / 1ps

// A result beat is registered: it appears in the cycle after the input beat that causes it.
// Throughput: one input byte per cycle while each byte makes at most one result and m_tready is
// high; a kept NALU's length byte makes one beat per start-code byte, and the final byte of a
// record one more for its status; the output register sends these one beat a cycle, holding s_tready low.
// Reset (rst_n, asynchronous, active low) returns the parser to the header phase,
// empties the output register and loads the kept NALU types 32, 33 and 34.
module hvcc_parameter_set_extractor
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic        s_tlast,   // end_of_record

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte[7:0], nalu_end[8], nalu_total_length[25:9],
                                   // length_field_size[28:26], status[30:29], zero[31]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast    // run_last
);

    hpse_pkg::keep_cfg_t cfg;
    hpse_pkg::bundle_t   bundle;
    logic                can_load;
    logic                take;

    assign s_tready = can_load;
    assign take     = s_tvalid && can_load;

    hpse_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hpse_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .in_byte       (s_tdata),
        .end_of_record (s_tlast),
        .cfg           (cfg),
        .bundle        (bundle)
    );

    hpse_emitter u_emitter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .bundle   (bundle),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- design/hpse_cfg_regs.sv -----
`timescale 1ns / 1ps

module hpse_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output hpse_pkg::keep_cfg_t cfg
);

    logic [5:0] keep_first_reg;
    logic [5:0] keep_second_reg;
    logic [5:0] keep_third_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_first_reg  <= hpse_pkg::KEEP_FIRST_RST;
            keep_second_reg <= hpse_pkg::KEEP_SECOND_RST;
            keep_third_reg  <= hpse_pkg::KEEP_THIRD_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                hpse_pkg::REG_KEEP_FIRST:  keep_first_reg  <= pwdata[5:0];
                hpse_pkg::REG_KEEP_SECOND: keep_second_reg <= pwdata[5:0];
                hpse_pkg::REG_KEEP_THIRD:  keep_third_reg  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            hpse_pkg::REG_KEEP_FIRST:  prdata = {26'd0, keep_first_reg};
            hpse_pkg::REG_KEEP_SECOND: prdata = {26'd0, keep_second_reg};
            hpse_pkg::REG_KEEP_THIRD:  prdata = {26'd0, keep_third_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg.keep_first  = keep_first_reg;
    assign cfg.keep_second = keep_second_reg;
    assign cfg.keep_third  = keep_third_reg;

endmodule

// ----- design/hpse_parser.sv -----
`timescale 1ns / 1ps

module hpse_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          in_byte,
    input  logic                end_of_record,
    input  hpse_pkg::keep_cfg_t cfg,
    output hpse_pkg::bundle_t   bundle
);

    localparam logic [hpse_pkg::POS_W-1:0] POS_MAX   = {hpse_pkg::POS_W{1'b1}};
    localparam logic [hpse_pkg::POS_W-1:0] POS_LSIZE =
        hpse_pkg::POS_W'(hpse_pkg::LSIZE_BYTE_POS);
    localparam logic [hpse_pkg::POS_W-1:0] POS_HDR_LAST =
        hpse_pkg::POS_W'(hpse_pkg::HEADER_BYTES - 1);
    localparam logic [hpse_pkg::POS_W-1:0] POS_MIN =
        hpse_pkg::POS_W'(hpse_pkg::MIN_RECORD_BYTES);
    localparam logic [hpse_pkg::CNT_W-1:0] SC_CNT =
        hpse_pkg::CNT_W'(hpse_pkg::START_CODE_BYTES);
    localparam logic [hpse_pkg::TOTAL_W-1:0] SC_TOTAL =
        hpse_pkg::TOTAL_W'(hpse_pkg::START_CODE_BYTES);

    hpse_pkg::phase_t             phase_reg, phase_next;
    logic [hpse_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]                   arrays_reg, arrays_next;
    logic [15:0]                  nalus_reg, nalus_next;
    logic [15:0]                  remain_reg, remain_next;
    logic [7:0]                   hi_reg, hi_next;
    logic                         kept_reg, kept_next;
    logic [15:0]                  plen_reg, plen_next;

    logic [5:0]                   nalu_type;
    logic [15:0]                  field_word;
    logic [15:0]                  nalus_dec;
    logic [15:0]                  remain_dec;
    hpse_pkg::bundle_t            b;

    assign nalu_type  = in_byte[5:0] & hpse_pkg::TYPE_MASK;
    assign field_word = {hi_reg, in_byte};
    assign nalus_dec  = nalus_reg - 16'd1;
    assign remain_dec = remain_reg - 16'd1;

    // Advance the parse for one byte and collect its results
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        arrays_next = arrays_reg;
        nalus_next  = nalus_reg;
        remain_next = remain_reg;
        hi_next     = hi_reg;
        kept_next   = kept_reg;
        plen_next   = plen_reg;
        b           = '0;

        case (phase_reg)
            hpse_pkg::PH_HEADER:
            begin
                if (pos_reg == POS_LSIZE)
                begin
                    b.has_lsize = 1'b1;
                    b.lsize     = {1'b0, in_byte[1:0] & hpse_pkg::LSIZE_MASK} + 3'd1;
                end
                if (pos_reg >= POS_HDR_LAST)
                    phase_next = hpse_pkg::PH_COUNT;
            end
            hpse_pkg::PH_COUNT:
            begin
                arrays_next = in_byte;
                phase_next  = hpse_pkg::PH_TYPE;
            end
            hpse_pkg::PH_TYPE:
            begin
                if (arrays_reg != 8'd0)
                begin
                    kept_next  = (nalu_type == cfg.keep_first) ||
                                 (nalu_type == cfg.keep_second) ||
                                 (nalu_type == cfg.keep_third);
                    phase_next = hpse_pkg::PH_NCOUNT_HI;
                end
            end
            hpse_pkg::PH_NCOUNT_HI:
            begin
                hi_next    = in_byte;
                phase_next = hpse_pkg::PH_NCOUNT_LO;
            end
            hpse_pkg::PH_NCOUNT_LO:
            begin
                nalus_next  = field_word;
                arrays_next = arrays_reg - 8'd1;
                phase_next  = (field_word == 16'd0) ? hpse_pkg::PH_TYPE : hpse_pkg::PH_LEN_HI;
            end
            hpse_pkg::PH_LEN_HI:
            begin
                hi_next    = in_byte;
                phase_next = hpse_pkg::PH_LEN_LO;
            end
            hpse_pkg::PH_LEN_LO:
            begin
                plen_next   = field_word;
                remain_next = field_word;
                if (kept_reg)
                begin
                    b.has_sc = 1'b1;
                    b.sc_end = (field_word == 16'd0);
                    b.total  = (field_word == 16'd0) ? SC_TOTAL : '0;
                end
                if (field_word == 16'd0)
                begin
                    nalus_next = nalus_dec;
                    phase_next = (nalus_dec == 16'd0) ? hpse_pkg::PH_TYPE
                                                      : hpse_pkg::PH_LEN_HI;
                end
                else
                begin
                    phase_next = hpse_pkg::PH_PAYLOAD;
                end
            end
            default:
            begin
                remain_next = remain_dec;
                if (kept_reg)
                begin
                    b.has_byte = 1'b1;
                    b.data     = in_byte;
                    b.byte_end = (remain_dec == 16'd0);
                    b.total    = (remain_dec == 16'd0) ? SC_TOTAL + {1'b0, plen_reg} : '0;
                end
                if (remain_dec == 16'd0)
                begin
                    nalus_next = nalus_dec;
                    phase_next = (nalus_dec == 16'd0) ? hpse_pkg::PH_TYPE
                                                      : hpse_pkg::PH_LEN_HI;
                end
            end
        endcase

        // Close the record: report status and drop parse state
        if (end_of_record)
        begin
            b.has_status = 1'b1;
            if (pos_next < POS_MIN)
                b.status = hpse_pkg::ST_SHORT;
            else if ((phase_next == hpse_pkg::PH_TYPE) && (arrays_next == 8'd0))
                b.status = hpse_pkg::ST_OK;
            else
                b.status = hpse_pkg::ST_TRUNCATED;
            phase_next  = hpse_pkg::PH_HEADER;
            pos_next    = '0;
            arrays_next = '0;
            nalus_next  = '0;
            remain_next = '0;
            hi_next     = '0;
            kept_next   = 1'b0;
            plen_next   = '0;
        end

        b.count = hpse_pkg::CNT_W'(b.has_lsize) + (b.has_sc ? SC_CNT : '0) +
                  hpse_pkg::CNT_W'(b.has_byte) + hpse_pkg::CNT_W'(b.has_status);
    end

    assign bundle = b;

    // Hold parse state between accepted beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hpse_pkg::PH_HEADER;
            pos_reg    <= '0;
            arrays_reg <= '0;
            nalus_reg  <= '0;
            remain_reg <= '0;
            hi_reg     <= '0;
            kept_reg   <= 1'b0;
            plen_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            arrays_reg <= arrays_next;
            nalus_reg  <= nalus_next;
            remain_reg <= remain_next;
            hi_reg     <= hi_next;
            kept_reg   <= kept_next;
            plen_reg   <= plen_next;
        end
    end

endmodule

// ----- design/hpse_emitter.sv -----
`timescale 1ns / 1ps

module hpse_emitter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hpse_pkg::bundle_t bundle,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // out_byte[7:0], nalu_end[8], nalu_total_length[25:9],
                                         // length_field_size[28:26], status[30:29], zero[31]
    output logic [1:0]        m_tuser,   // kind[1:0]
    output logic              m_tlast    // run_last
);

    localparam logic [hpse_pkg::CNT_W-1:0] SC_CNT =
        hpse_pkg::CNT_W'(hpse_pkg::START_CODE_BYTES);
    localparam logic [hpse_pkg::CNT_W-1:0] SC_LAST =
        hpse_pkg::CNT_W'(hpse_pkg::START_CODE_BYTES - 1);

    hpse_pkg::bundle_t            bundle_reg;
    logic [hpse_pkg::CNT_W-1:0]   idx_reg;
    logic [hpse_pkg::CNT_W-1:0]   idx_inc;
    logic [hpse_pkg::CNT_W-1:0]   front_cnt;
    logic                         busy;
    logic                         last_beat;

    logic [1:0]                   kind;
    logic [7:0]                   out_byte;
    logic                         nalu_end;
    logic [hpse_pkg::TOTAL_W-1:0] total;
    logic [2:0]                   lsize;
    logic [1:0]                   status;

    assign idx_inc   = idx_reg + 1'b1;
    assign busy      = (idx_reg != bundle_reg.count);
    assign last_beat = (idx_inc == bundle_reg.count);
    assign can_load  = !busy || (m_tready && last_beat);

    // Load a new bundle or step through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bundle_reg <= '0;
            idx_reg    <= '0;
        end
        else if (load)
        begin
            bundle_reg <= bundle;
            idx_reg    <= '0;
        end
        else if (busy && m_tready)
        begin
            idx_reg <= idx_inc;
        end
    end

    // Select the beat at the current index
    always_comb
    begin
        front_cnt = hpse_pkg::CNT_W'(bundle_reg.has_lsize) +
                    (bundle_reg.has_sc ? SC_CNT : '0) +
                    hpse_pkg::CNT_W'(bundle_reg.has_byte);
        kind     = hpse_pkg::KIND_NALU;
        out_byte = '0;
        nalu_end = 1'b0;
        total    = '0;
        lsize    = '0;
        status   = '0;
        if (idx_reg >= front_cnt)
        begin
            kind   = hpse_pkg::KIND_STATUS;
            status = bundle_reg.status;
        end
        else if (bundle_reg.has_lsize)
        begin
            kind  = hpse_pkg::KIND_LSIZE;
            lsize = bundle_reg.lsize;
        end
        else if (bundle_reg.has_sc)
        begin
            if (idx_reg == SC_LAST)
            begin
                out_byte = 8'd1;
                nalu_end = bundle_reg.sc_end;
                total    = bundle_reg.total;
            end
        end
        else
        begin
            out_byte = bundle_reg.data;
            nalu_end = bundle_reg.byte_end;
            total    = bundle_reg.total;
        end
    end

    assign m_tvalid = busy;
    assign m_tdata  = {1'b0, status, lsize, total, nalu_end, out_byte};
    assign m_tuser  = kind;
    assign m_tlast  = last_beat;

endmodule

// ----- design/hpse_checker.sv -----
`timescale 1ns / 1ps

module hpse_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Hold a stalled beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // Status always closes the results of its byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == hpse_pkg::KIND_STATUS) |-> m_tlast)
        else $error("status beat not marked last");

    // NALU end only on NALU bytes, with a total covering the start code
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |->
            (m_tuser == hpse_pkg::KIND_NALU) &&
            (m_tdata[25:9] >= 17'(hpse_pkg::START_CODE_BYTES)))
        else $error("bad NALU end beat");

    // Length-size report is never zero and at most 4
    a_lsize_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == hpse_pkg::KIND_LSIZE) |->
            (m_tdata[28:26] != 3'd0) && (m_tdata[28:26] <= 3'd4))
        else $error("length size out of range");

endmodule

bind hvcc_parameter_set_extractor hpse_checker u_hpse_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [7:0]                  data;
        logic                        nend;
        logic [hpse_pkg::TOTAL_W-1:0] total;
        logic [2:0]                  lsize;
        logic [1:0]                  status;
        logic                        tail;
    } result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eor;
    } feed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // in_byte[7:0]
    logic        s_tlast = 1'b0;   // end_of_record
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // out_byte[7:0], nalu_end[8], nalu_total_length[25:9],
                                   // length_field_size[28:26], status[30:29], zero[31]
    logic [1:0]  m_tuser;          // kind[1:0]
    logic        m_tlast;          // run_last

    hvcc_parameter_set_extractor uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Byte feed, expected results and run bookkeeping
    feed_t      feed_q[$];
    result_t    expected_q[$];
    logic [7:0] rec_buf[$];
    logic       in_fire = 1'b0;
    int         in_gap = 0;
    int         in_calm = 0;
    int         out_gap = 0;
    int         out_calm = 0;
    int         cycles = 0;
    int         fail_count = 0;
    int         records = 0;
    int         body_bytes = 0;
    int         beats_in = 0;
    int         beats_out = 0;
    int         settings = 1;

    // Parser state mirrored for prediction
    logic [5:0]        keep_sel[3];
    hpse_pkg::phase_t  parse_ph;
    logic [6:0]        rec_pos;
    logic [7:0]        arrays_left;
    logic [15:0]       nalus_left;
    logic [15:0]       pay_left;
    logic [15:0]       pay_len;
    logic [7:0]        hi_byte;
    logic              kept;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     expected_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] data,
                                            input logic nend,
                                            input logic [hpse_pkg::TOTAL_W-1:0] total,
                                            input logic [2:0] lsize, input logic [1:0] status);
        result_t r;
        r.kind   = kind;
        r.data   = data;
        r.nend   = nend;
        r.total  = total;
        r.lsize  = lsize;
        r.status = status;
        r.tail   = 1'b0;
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display("[%0t] %s", $time, msg);
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("kind %0d byte %02h end %0d total %0d lsize %0d status %0d last %0d",
                         r.kind, r.data, r.nend, r.total, r.lsize, r.status, r.tail);
    endfunction

    task automatic clear_parse();
        parse_ph    = hpse_pkg::PH_HEADER;
        rec_pos     = '0;
        arrays_left = '0;
        nalus_left  = '0;
        pay_left    = '0;
        pay_len     = '0;
        hi_byte     = '0;
        kept        = 1'b0;
    endtask

    task automatic close_nalu();
        nalus_left = nalus_left - 16'd1;
        parse_ph = (nalus_left == 16'd0) ? hpse_pkg::PH_TYPE : hpse_pkg::PH_LEN_HI;
    endtask

    task automatic queue_result(input result_t r);
        expected_q.insert(expected_q.size(), r);
    endtask

    // Work out the result beats one record byte causes
    task automatic predict_extract(input logic [7:0] b, input logic eor);
        result_t    res[6];
        int         n;
        int         idx;
        logic [5:0] t;
        logic [1:0] st;
        logic       sc_end;
        n = 0;
        idx = int'(rec_pos);
        if (rec_pos < 7'd127)
            rec_pos = rec_pos + 7'd1;
        case (parse_ph)
            hpse_pkg::PH_HEADER:
            begin
                if (idx == hpse_pkg::LSIZE_BYTE_POS)
                begin
                    res[n] = make_result(hpse_pkg::KIND_LSIZE, 8'd0, 1'b0, '0,
                                         {1'b0, b[1:0] & hpse_pkg::LSIZE_MASK} + 3'd1,
                                         hpse_pkg::ST_OK);
                    n++;
                end
                if (idx + 1 >= hpse_pkg::HEADER_BYTES)
                    parse_ph = hpse_pkg::PH_COUNT;
            end
            hpse_pkg::PH_COUNT:
            begin
                arrays_left = b;
                parse_ph = hpse_pkg::PH_TYPE;
            end
            hpse_pkg::PH_TYPE:
            begin
                // trailing bytes after the last array fall through here
                if (arrays_left != 8'd0)
                begin
                    t = b[5:0] & hpse_pkg::TYPE_MASK;
                    kept = (t == keep_sel[0]) || (t == keep_sel[1]) || (t == keep_sel[2]);
                    parse_ph = hpse_pkg::PH_NCOUNT_HI;
                end
            end
            hpse_pkg::PH_NCOUNT_HI:
            begin
                hi_byte = b;
                parse_ph = hpse_pkg::PH_NCOUNT_LO;
            end
            hpse_pkg::PH_NCOUNT_LO:
            begin
                nalus_left = {hi_byte, b};
                arrays_left = arrays_left - 8'd1;
                parse_ph = (nalus_left == 16'd0) ? hpse_pkg::PH_TYPE : hpse_pkg::PH_LEN_HI;
            end
            hpse_pkg::PH_LEN_HI:
            begin
                hi_byte = b;
                parse_ph = hpse_pkg::PH_LEN_LO;
            end
            hpse_pkg::PH_LEN_LO:
            begin
                pay_len = {hi_byte, b};
                pay_left = pay_len;
                // whole start code goes out on the length low byte
                if (kept)
                begin
                    for (int i = 0; i < hpse_pkg::START_CODE_BYTES; i++)
                    begin
                        sc_end = (i == hpse_pkg::START_CODE_BYTES - 1) && (pay_len == 16'd0);
                        res[n] = make_result(hpse_pkg::KIND_NALU,
                                             (i == hpse_pkg::START_CODE_BYTES - 1) ?
                                             8'd1 : 8'd0,
                                             sc_end,
                                             sc_end ?
                                             hpse_pkg::TOTAL_W'(hpse_pkg::START_CODE_BYTES) :
                                             '0,
                                             3'd0, hpse_pkg::ST_OK);
                        n++;
                    end
                end
                if (pay_len == 16'd0)
                    close_nalu();
                else
                    parse_ph = hpse_pkg::PH_PAYLOAD;
            end
            default:
            begin
                pay_left = pay_left - 16'd1;
                if (kept)
                begin
                    res[n] = make_result(hpse_pkg::KIND_NALU, b, pay_left == 16'd0,
                                         (pay_left == 16'd0) ?
                                         hpse_pkg::TOTAL_W'(hpse_pkg::START_CODE_BYTES) +
                                         hpse_pkg::TOTAL_W'(pay_len) : '0,
                                         3'd0, hpse_pkg::ST_OK);
                    n++;
                end
                if (pay_left == 16'd0)
                    close_nalu();
            end
        endcase

        // Close the record with its status
        if (eor)
        begin
            if (int'(rec_pos) < hpse_pkg::MIN_RECORD_BYTES)
                st = hpse_pkg::ST_SHORT;
            else if (parse_ph == hpse_pkg::PH_TYPE && arrays_left == 8'd0)
                st = hpse_pkg::ST_OK;
            else
                st = hpse_pkg::ST_TRUNCATED;
            res[n] = make_result(hpse_pkg::KIND_STATUS, 8'd0, 1'b0, '0, 3'd0, st);
            n++;
            clear_parse();
        end

        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                res[i].tail = 1'b1;
            queue_result(res[i]);
        end
    endtask

    // Predict on accepted input beats, check accepted output beats
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        in_fire <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                beats_in++;
                predict_extract(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                beats_out++;
                got.kind   = m_tuser;
                got.data   = m_tdata[7:0];
                got.nend   = m_tdata[8];
                got.total  = m_tdata[25:9];
                got.lsize  = m_tdata[28:26];
                got.status = m_tdata[30:29];
                got.tail   = m_tlast;
                if (expected_q.size() == 0)
                begin
                    note_failure({"unexpected beat: ", fmt_result(got)});
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                        note_failure({"mismatch: expected ", fmt_result(want),
                                      " got ", fmt_result(got)});
                end
            end
        end
    end

    // Input driver: present bytes from the feed queue with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (feed_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= feed_q[0].data;
                s_tlast <= feed_q[0].eor;
                feed_q.delete(0);
                in_gap <= idle_len(in_calm);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: stall at random
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            m_tready <= 1'b0;
            out_gap <= out_gap - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                out_gap <= idle_len(out_calm);
        end
    end

    task automatic apb_write(input logic [1:0] reg_idx, input logic [5:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {26'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        keep_sel[reg_idx] = value;
    endtask

    task automatic apply_keep(input logic [5:0] first, input logic [5:0] second,
                              input logic [5:0] third);
        apb_write(hpse_pkg::REG_KEEP_FIRST, first);
        apb_write(hpse_pkg::REG_KEEP_SECOND, second);
        apb_write(hpse_pkg::REG_KEEP_THIRD, third);
        settings++;
    endtask

    // Hold until every byte is taken and every result is back, then let the block settle
    task automatic wait_drained();
        while (feed_q.size() > 0 || s_tvalid || expected_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_byte(input logic [7:0] v);
        rec_buf.insert(rec_buf.size(), v);
    endtask

    task automatic start_record(input logic [7:0] b21);
        rec_buf.delete();
        for (int i = 0; i < hpse_pkg::HEADER_BYTES; i++)
            queue_byte((i == hpse_pkg::LSIZE_BYTE_POS) ? b21 : 8'($urandom_range(0, 255)));
    endtask

    task automatic put16(input logic [15:0] v);
        queue_byte(v[15:8]);
        queue_byte(v[7:0]);
    endtask

    task automatic end_record();
        feed_t f;
        for (int i = 0; i < rec_buf.size(); i++)
        begin
            f.data = rec_buf[i];
            f.eor  = (i == rec_buf.size() - 1);
            feed_q.insert(feed_q.size(), f);
        end
        if (rec_buf.size() > hpse_pkg::HEADER_BYTES)
            body_bytes += rec_buf.size() - hpse_pkg::HEADER_BYTES;
        records++;
    endtask

    // Random record: mostly well formed, some cut short, corrupted or too short
    task automatic add_random_record();
        int narr;
        int nn;
        int len;
        int shape;
        int cut;
        logic [5:0] t;
        start_record(8'($urandom_range(0, 255)));
        narr = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 3);
        queue_byte(8'(narr));
        for (int a = 0; a < narr; a++)
        begin
            t = ($urandom_range(0, 9) < 6) ? keep_sel[$urandom_range(0, 2)]
                                           : 6'($urandom_range(0, 63));
            queue_byte({2'($urandom_range(0, 3)), t});
            nn = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            put16(16'(nn));
            for (int k = 0; k < nn; k++)
            begin
                len = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 5) : $urandom_range(16, 40);
                put16(16'(len));
                for (int j = 0; j < len; j++)
                    queue_byte(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));

        shape = $urandom_range(0, 99);
        if (shape >= 70 && shape < 82 && rec_buf.size() > hpse_pkg::HEADER_BYTES + 2)
        begin
            cut = $urandom_range(hpse_pkg::HEADER_BYTES + 1, rec_buf.size() - 1);
            while (rec_buf.size() > cut)
                void'(rec_buf.pop_back());
        end
        else if (shape >= 82 && shape < 92)
        begin
            cut = $urandom_range(hpse_pkg::HEADER_BYTES, rec_buf.size() - 1);
            rec_buf[cut] = 8'($urandom_range(0, 255));
        end
        else if (shape >= 92)
        begin
            cut = $urandom_range(1, hpse_pkg::MIN_RECORD_BYTES - 1);
            while (rec_buf.size() > cut)
                void'(rec_buf.pop_back());
        end
        end_record();
    endtask

    initial
    begin
        keep_sel[0] = hpse_pkg::KEEP_FIRST_RST;
        keep_sel[1] = hpse_pkg::KEEP_SECOND_RST;
        keep_sel[2] = hpse_pkg::KEEP_THIRD_RST;
        clear_parse();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed records under the reset keep types
        rec_buf.delete();
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h5A);
        end_record();

        // Kept and skipped arrays, a zero-length NALU and an empty array, then a trailing byte
        start_record(8'hFC);
        queue_byte(8'd4);
        queue_byte(8'h20);
        put16(16'd2);
        put16(16'd0);
        put16(16'd2);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'hE1);
        put16(16'd1);
        put16(16'd1);
        queue_byte(8'h7E);
        queue_byte(8'h13);
        put16(16'd1);
        put16(16'd2);
        queue_byte(8'h11);
        queue_byte(8'h22);
        queue_byte(8'h22);
        put16(16'd0);
        queue_byte(8'hAA);
        end_record();

        // Ends inside a payload
        start_record(8'h01);
        queue_byte(8'd1);
        queue_byte(8'h22);
        put16(16'd1);
        put16(16'd3);
        queue_byte(8'h80);
        queue_byte(8'h01);
        end_record();
        wait_drained();

        // Random record under random keep types
        apply_keep(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)));
        add_random_record();
        wait_drained();

        repeat (20) @(posedge clk);
        $display("covered %0d records (%0d bytes past the headers) in %0d input beats",
                 records, body_bytes, beats_in);
        $display("%0d result beats checked over %0d keep-type settings, failures: %0d",
                 beats_out, settings, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
